### hw/rtl/lfmc_pkg.sv
// Package for the line-follow motor controller.
// Holds the field widths, codes, constants and steering helpers.
// No dependencies.
`timescale 1ns / 1ps

package lfmc_pkg;

	// Field widths
	localparam int NumSensors = 6;
	localparam int SensW      = 10;
	localparam int PosW       = 13;
	localparam int SpeedW     = 10;
	localparam int LimitW     = 9;
	localparam int ErrW       = 14;  // position - center, signed
	localparam int DiffW      = 12;  // error / 4, signed
	localparam int SumW       = 13;  // limit +/- diff, signed

	// Stream payload widths (tdata padded to whole bytes)
	localparam int InDataW  = 80;
	localparam int OutDataW = 24;

	// Operation codes carried in tuser
	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Turn modes
	localparam logic [1:0] MODE_STRAIGHT = 2'd0;
	localparam logic [1:0] MODE_RIGHT    = 2'd1;
	localparam logic [1:0] MODE_LEFT     = 2'd2;
	localparam logic [1:0] MODE_UNKNOWN  = 2'd3;

	// Register map (index = paddr[2])
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_LIMIT     = 1'b1;

	localparam logic [SensW-1:0]  THRESHOLD_RST = 10'd800;
	localparam logic [LimitW-1:0] LIMIT_RST     = 9'd200;

	// Position constants
	localparam logic [PosW-1:0] POS_CENTER     = 13'd2500;
	localparam logic [PosW-1:0] POS_RIGHT_NONE = 13'd5000;
	localparam logic [PosW-1:0] POS_MID_LOW    = 13'd2000;
	localparam logic [PosW-1:0] POS_MID_HIGH   = 13'd3000;

	// Position of each sensor, 1000 per index
	localparam logic [PosW-1:0] SENSOR_POS [NumSensors] = '{
		13'd0, 13'd1000, 13'd2000, 13'd3000, 13'd4000, 13'd5000
	};

	// One input item
	typedef struct packed {
		logic [SensW-1:0] sensor_5;
		logic [SensW-1:0] sensor_4;
		logic [SensW-1:0] sensor_3;
		logic [SensW-1:0] sensor_2;
		logic [SensW-1:0] sensor_1;
		logic [SensW-1:0] sensor_0;
		logic [PosW-1:0]  position;
		logic [1:0]       turn_request;
		logic             op;
	} item_t;

	// Turn right: highest sensor on the line, or far right when none is
	function automatic logic [PosW-1:0] right_pos(input logic [NumSensors-1:0] seen);
		logic [PosW-1:0] p;
		p = POS_RIGHT_NONE;
		for (int i = 0; i < NumSensors; i++) begin
			if (seen[i]) p = SENSOR_POS[i];
		end
		return p;
	endfunction

	// Turn left: lowest sensor on the line, or far left when none is
	function automatic logic [PosW-1:0] left_pos(input logic [NumSensors-1:0] seen);
		logic [PosW-1:0] p;
		p = '0;
		for (int i = NumSensors - 1; i >= 0; i--) begin
			if (seen[i]) p = SENSOR_POS[i];
		end
		return p;
	endfunction

endpackage

### hw/rtl/line_follow_motor_control.sv
// Line-follow motor controller: top level, input register, steering logic,
// output register and APB register file.
// Depends on lfmc_pkg.
`timescale 1ns / 1ps

//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+------------------------------------------
//  s_*       | in        | s_tvalid/s_tready  | tuser: op; tdata: turn_request, position,
//            |           |                    |        sensor_0..sensor_5
//  m_*       | out       | m_tvalid/m_tready  | tdata: left_speed, right_speed;
//            |           |                    | tuser: at_intersection, running
//  apb       | in        | psel/penable/pready| line_threshold @0x0, speed_limit @0x4
//
// One item per cycle while m_tready keeps the output register draining; each result passes
// from the input register into the result register, which drives m_*.
// arst_n clears the run state, the valid flags and the registers to their defaults.
// A stalled result holds in the output register while the input register still
// takes one more item; s_tready drops only when both are full.

module line_follow_motor_control
	import lfmc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // turn_request[1:0], position[14:2],
	                                       // sensor_0..5 [24:15]..[74:65], zero pad
	input  logic                s_tuser,   // op
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // left_speed[9:0], right_speed[19:10], zero pad
	output logic [1:0]          m_tuser,   // at_intersection[0], running[1]
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// Configuration registers
	logic [SensW-1:0]  threshold_q;
	logic [LimitW-1:0] limit_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			limit_q     <= LIMIT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_THRESHOLD: threshold_q <= pwdata[SensW-1:0];
				REG_LIMIT:     limit_q     <= pwdata[LimitW-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_THRESHOLD: prdata = {{(32-SensW){1'b0}}, threshold_q};
			REG_LIMIT:     prdata = {{(32-LimitW){1'b0}}, limit_q};
			default:       prdata = '0;
		endcase
	end

	// Flow control
	logic  valid_s1;
	item_t item_s1;
	logic  advance;

	assign advance  = valid_s1 & (~m_tvalid | m_tready);
	assign s_tready = ~valid_s1 | advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_t'({s_tdata[InDataW-6:0], s_tuser});
		end
	end

	// Line detection per sensor
	logic [NumSensors-1:0] seen;
	assign seen[0] = item_s1.sensor_0 > threshold_q;
	assign seen[1] = item_s1.sensor_1 > threshold_q;
	assign seen[2] = item_s1.sensor_2 > threshold_q;
	assign seen[3] = item_s1.sensor_3 > threshold_q;
	assign seen[4] = item_s1.sensor_4 > threshold_q;
	assign seen[5] = item_s1.sensor_5 > threshold_q;

	// Run state
	logic       run_q;
	logic [1:0] mode_q;

	// Steering
	logic                     back_to_mid;
	logic [1:0]               mode_eff;
	logic [PosW-1:0]          pos_sel;
	logic signed [ErrW-1:0]   err;
	logic signed [ErrW-1:0]   err_adj;
	logic signed [DiffW-1:0]  diff;
	logic signed [SumW-1:0]   lim_s;
	logic signed [SumW-1:0]   lsum;
	logic signed [SumW-1:0]   rsum;
	logic signed [SumW-1:0]   lclamp;
	logic signed [SumW-1:0]   rclamp;

	assign back_to_mid = (item_s1.position > POS_MID_LOW) && (item_s1.position < POS_MID_HIGH)
		&& seen[2] && seen[3] && !seen[1] && !seen[4];
	assign mode_eff = back_to_mid ? MODE_STRAIGHT : mode_q;

	always_comb begin
		case (mode_eff)
			MODE_RIGHT: pos_sel = right_pos(seen);
			MODE_LEFT:  pos_sel = left_pos(seen);
			default:    pos_sel = item_s1.position;
		endcase
	end

	// error / 4 rounded toward zero: bias negatives by 3 before the shift
	assign err     = signed'({1'b0, pos_sel}) - signed'({1'b0, POS_CENTER});
	assign err_adj = err + (err[ErrW-1] ? ErrW'(3) : ErrW'(0));
	assign diff    = DiffW'(err_adj >>> 2);

	assign lim_s = signed'(SumW'(limit_q));
	assign lsum  = lim_s + SumW'(diff);
	assign rsum  = lim_s - SumW'(diff);

	always_comb begin
		if (lsum > lim_s)       lclamp = lim_s;
		else if (lsum < -lim_s) lclamp = -lim_s;
		else                    lclamp = lsum;
		if (rsum > lim_s)       rclamp = lim_s;
		else if (rsum < -lim_s) rclamp = -lim_s;
		else                    rclamp = rsum;
	end

	// Next state and result for the item in the input register
	logic                     run_d;
	logic [1:0]               mode_d;
	logic signed [SpeedW-1:0] lspeed_d;
	logic signed [SpeedW-1:0] rspeed_d;
	logic                     inter_d;

	always_comb begin
		run_d    = run_q;
		mode_d   = mode_q;
		lspeed_d = '0;
		rspeed_d = '0;
		inter_d  = 1'b0;
		if (item_s1.op == OP_START) begin
			run_d  = 1'b1;
			mode_d = (item_s1.turn_request == MODE_UNKNOWN) ? MODE_STRAIGHT
				: item_s1.turn_request;
		end else if (run_q) begin
			if ((&seen) && mode_q == MODE_STRAIGHT) begin
				run_d   = 1'b0;
				inter_d = 1'b1;
			end else begin
				mode_d   = mode_eff;
				lspeed_d = SpeedW'(lclamp);
				rspeed_d = SpeedW'(rclamp);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			mode_q <= MODE_STRAIGHT;
		end else if (advance) begin
			run_q  <= run_d;
			mode_q <= mode_d;
		end
	end

	// Output register
	logic signed [SpeedW-1:0] lspeed_q;
	logic signed [SpeedW-1:0] rspeed_q;
	logic                     inter_q;
	logic                     running_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lspeed_q  <= lspeed_d;
			rspeed_q  <= rspeed_d;
			inter_q   <= inter_d;
			running_q <= run_d;
		end
	end

	assign m_tdata = {{(OutDataW - 2*SpeedW){1'b0}}, rspeed_q, lspeed_q};
	assign m_tuser = {running_q, inter_q};

	// Checks
	a_inter_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && inter_q |-> !running_q)
		else $error("intersection result still shows a run");

	a_idle_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !running_q |-> lspeed_q == '0 && rspeed_q == '0)
		else $error("nonzero speed with no run in progress");

	a_speed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (lspeed_q <= signed'(SpeedW'(limit_q)))
			&& (rspeed_q <= signed'(SpeedW'(limit_q))))
		else $error("speed beyond limit");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register changed while stalled");

	a_state_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(run_q) && $stable(mode_q))
		else $error("run state moved without a transfer");

endmodule

### sim/line_follow_motor_control_checker.sv
// Scoreboard for the line-follow motor controller: tracks register writes on the APB port,
// predicts one speed command per input transfer and compares the result stream in order.
// Depends on lfmc_pkg.
`timescale 1ns / 1ps

module line_follow_motor_control_checker
	import lfmc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,
	input  logic                s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OutDataW-1:0] m_tdata,
	input  logic [1:0]          m_tuser,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  results_seen,
	output int                  outstanding,
	output int                  intersections
);

	localparam int SensorStep = 1000;
	localparam int GainDiv    = 4;

	typedef struct packed {
		logic signed [SpeedW-1:0] left_speed;
		logic signed [SpeedW-1:0] right_speed;
		logic                     at_intersection;
		logic                     running;
	} speed_cmd_t;

	// Shadow of the controller state and registers
	logic [SensW-1:0]  line_thr;
	logic [LimitW-1:0] base_speed;
	logic              run_active;
	logic [1:0]        turn_mode;

	speed_cmd_t               cmd_queue [$];
	speed_cmd_t               want;
	logic signed [SpeedW-1:0] got_left;
	logic signed [SpeedW-1:0] got_right;
	int                       n_fail;
	int                       n_results;
	int                       n_inter;

	function automatic int saturate(input int v, input int lim);
		if (v < -lim) return -lim;
		if (v > lim) return lim;
		return v;
	endfunction

	// Next speed command for one input item; updates the run state
	function automatic speed_cmd_t steer(input item_t it);
		logic [NumSensors-1:0] seen;
		int                    pos;
		int                    diff;
		int                    lim;
		int                    i;
		bit                    hit;
		speed_cmd_t            cmd;
		cmd = '0;
		hit = 1'b0;
		lim = int'(base_speed);
		seen[0] = it.sensor_0 > line_thr;
		seen[1] = it.sensor_1 > line_thr;
		seen[2] = it.sensor_2 > line_thr;
		seen[3] = it.sensor_3 > line_thr;
		seen[4] = it.sensor_4 > line_thr;
		seen[5] = it.sensor_5 > line_thr;
		if (it.op == OP_START) begin
			run_active = 1'b1;
			turn_mode = (it.turn_request == MODE_UNKNOWN) ? MODE_STRAIGHT : it.turn_request;
		end else if (run_active) begin
			if (&seen && turn_mode == MODE_STRAIGHT) begin
				// whole bar on the line: intersection ends the run
				run_active = 1'b0;
				cmd.at_intersection = 1'b1;
			end else begin
				pos = int'(it.position);
				// line centered under the two middle sensors only: turn is done
				if (pos > int'(POS_MID_LOW) && pos < int'(POS_MID_HIGH) && seen[2] && seen[3] &&
					!seen[1] && !seen[4])
					turn_mode = MODE_STRAIGHT;
				if (turn_mode == MODE_RIGHT) begin
					pos = int'(POS_RIGHT_NONE);
					for (i = NumSensors - 1; i >= 0; i--) begin
						if (seen[i] && !hit) begin
							pos = i * SensorStep;
							hit = 1'b1;
						end
					end
				end else if (turn_mode == MODE_LEFT) begin
					pos = 0;
					for (i = 0; i < NumSensors; i++) begin
						if (seen[i] && !hit) begin
							pos = i * SensorStep;
							hit = 1'b1;
						end
					end
				end
				// signed division truncates toward zero
				diff = (pos - int'(POS_CENTER)) / GainDiv;
				cmd.left_speed  = SpeedW'(saturate(lim + diff, lim));
				cmd.right_speed = SpeedW'(saturate(lim - diff, lim));
			end
		end
		cmd.running = run_active;
		return cmd;
	endfunction

	// Watch register writes, input transfers and result transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_thr   = THRESHOLD_RST;
			base_speed = LIMIT_RST;
			run_active = 1'b0;
			turn_mode  = MODE_STRAIGHT;
			n_fail     = 0;
			n_results  = 0;
			n_inter    = 0;
			cmd_queue.delete();
			fail_count    <= 0;
			results_seen  <= 0;
			outstanding   <= 0;
			intersections <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[2])
					REG_THRESHOLD: line_thr = pwdata[SensW-1:0];
					REG_LIMIT:     base_speed = pwdata[LimitW-1:0];
					default:       ;
				endcase
			end
			if (s_tvalid && s_tready)
				cmd_queue = {cmd_queue,
					steer(item_t'({s_tdata[$bits(item_t)-2:0], s_tuser}))};
			if (m_tvalid && m_tready) begin
				n_results++;
				got_left  = m_tdata[SpeedW-1:0];
				got_right = m_tdata[2*SpeedW-1:SpeedW];
				if (m_tuser[0]) n_inter++;
				if (cmd_queue.size() == 0) begin
					$error("result transfer with nothing expected: left_speed %0d right_speed %0d",
						got_left, got_right);
					n_fail++;
				end else begin
					want = cmd_queue.pop_front();
					if (got_left !== want.left_speed) begin
						$error("left_speed: expected %0d, got %0d", want.left_speed, got_left);
						n_fail++;
					end
					if (got_right !== want.right_speed) begin
						$error("right_speed: expected %0d, got %0d", want.right_speed, got_right);
						n_fail++;
					end
					if (m_tuser[0] !== want.at_intersection) begin
						$error("at_intersection: expected %0d, got %0d", want.at_intersection,
							m_tuser[0]);
						n_fail++;
					end
					if (m_tuser[1] !== want.running) begin
						$error("running: expected %0d, got %0d", want.running, m_tuser[1]);
						n_fail++;
					end
				end
			end
			fail_count    <= n_fail;
			results_seen  <= n_results;
			outstanding   <= cmd_queue.size();
			intersections <= n_inter;
		end
	end

endmodule

### sim/line_follow_motor_control_test.sv
// Testbench top for the line-follow motor controller: clock, reset, stream and APB
// stimulus with random idling, and the final verdict.
// Depends on lfmc_pkg, line_follow_motor_control and line_follow_motor_control_checker.
`timescale 1ns / 1ps

module line_follow_motor_control_test;
	import lfmc_pkg::*;

	localparam int ResultLatency = 2;
	localparam int PhaseItems    = 150;
	localparam int NumPhases     = 7;
	localparam int CycleLimit    = 200000;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;   // turn_request, position, sensor_0..sensor_5, zero pad
	logic                s_tuser;   // op
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;   // left_speed, right_speed, zero pad
	logic [1:0]          m_tuser;   // at_intersection, running
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	int fail_count;
	int results_seen;
	int outstanding;
	int intersections;

	int items_sent;
	int starts;
	int settings;
	int cur_thr;
	int cycles;
	bit gaps_on;
	bit stalls_on;

	line_follow_motor_control dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	line_follow_motor_control_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.results_seen  (results_seen),
		.outstanding   (outstanding),
		.intersections (intersections)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Result side backpressure
	always @(posedge clk) begin
		m_tready <= !stalls_on || ($urandom_range(99) >= 19);
	end

	// Run time guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("line_follow_motor_control_test: errors");
			$finish;
		end
	end

	// Directed item: sensors in mask read level, the others read zero
	function automatic item_t mk(input logic op, input logic [1:0] req, input int pos,
		input logic [NumSensors-1:0] mask, input int level);
		item_t it;
		it.op           = op;
		it.turn_request = req;
		it.position     = PosW'(pos);
		it.sensor_0     = mask[0] ? SensW'(level) : '0;
		it.sensor_1     = mask[1] ? SensW'(level) : '0;
		it.sensor_2     = mask[2] ? SensW'(level) : '0;
		it.sensor_3     = mask[3] ? SensW'(level) : '0;
		it.sensor_4     = mask[4] ? SensW'(level) : '0;
		it.sensor_5     = mask[5] ? SensW'(level) : '0;
		return it;
	endfunction

	// Random reading, mostly on the requested side of the current threshold, sometimes zero or full scale
	function automatic logic [SensW-1:0] reading(input bit on_line);
		int r;
		r = $urandom_range(99);
		if (r < 5) return '0;
		if (r < 10) return '1;
		if (on_line)
			return (cur_thr < 1023) ? SensW'($urandom_range(1023, cur_thr + 1))
			                        : SensW'($urandom_range(1023, 0));
		return SensW'($urandom_range(cur_thr, 0));
	endfunction

	// Random sample, biased toward intersections and the back-to-straight pattern
	function automatic item_t rand_sample();
		item_t                 it;
		logic [NumSensors-1:0] on;
		int                    r;
		it.op           = OP_SAMPLE;
		it.turn_request = 2'($urandom_range(3));
		on = NumSensors'($urandom);
		r  = $urandom_range(99);
		if (r < 8)
			on = '1;
		else if (r < 20)
			on = {on[5], 1'b0, 2'b11, 1'b0, on[0]};
		if (r >= 8 && r < 20)
			it.position = PosW'($urandom_range(3000, 2000));
		else if ($urandom_range(99) < 15)
			it.position = PosW'($urandom_range(8191, 0));
		else
			it.position = PosW'($urandom_range(5000, 0));
		it.sensor_0 = reading(on[0]);
		it.sensor_1 = reading(on[1]);
		it.sensor_2 = reading(on[2]);
		it.sensor_3 = reading(on[3]);
		it.sensor_4 = reading(on[4]);
		it.sensor_5 = reading(on[5]);
		return it;
	endfunction

	// One input transfer, with random idle cycles ahead of it
	task automatic send_item(input item_t it);
		while (gaps_on && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= InDataW'(it >> 1);
		s_tuser  <= it.op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		if (it.op == OP_START) starts++;
	endtask

	task automatic apb_write(input logic [2:0] addr, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drain all results, then let the pipeline settle
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_seen < items_sent) @(posedge clk);
		repeat (ResultLatency + 2) @(posedge clk);
	endtask

	// Runs of start plus samples with random content, and some stray samples
	task automatic random_phase(input int n);
		int    sent;
		int    len;
		int    j;
		item_t it;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 10) begin
				send_item(rand_sample());
				sent++;
			end else begin
				it = rand_sample();
				it.op = OP_START;
				send_item(it);
				sent++;
				len = $urandom_range(16, 1);
				for (j = 0; j < len && sent < n; j++) begin
					send_item(rand_sample());
					sent++;
				end
			end
		end
	endtask

	initial begin
		int p;
		int thr;
		int lim;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		m_tready  <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		cycles    <= 0;
		items_sent = 0;
		starts     = 0;
		settings   = 1;
		cur_thr    = int'(THRESHOLD_RST);
		gaps_on    = 1'b1;
		stalls_on  = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset register values
		send_item(mk(OP_SAMPLE, MODE_UNKNOWN, 8191, 6'h3F, 1023));  // sample while idle
		send_item(mk(OP_START, MODE_STRAIGHT, 0, 6'h00, 0));
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 2500, 6'h00, 0));
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 0, 6'h00, 0));
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 5000, 6'h00, 0));
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 8191, 6'h01, 1023));
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 2497, 6'h00, 0));    // truncation toward zero
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 2493, 6'h00, 0));
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 2500, 6'h3F, 1023)); // intersection
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 2500, 6'h00, 0));    // idle after the stop
		send_item(mk(OP_START, MODE_RIGHT, 0, 6'h00, 0));
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 1000, 6'h00, 0));    // right, nothing seen
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 1000, 6'h12, 900));
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 1000, 6'h3F, 900));  // all seen while turning
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 2600, 6'h0C, 900));  // back to straight
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 2600, 6'h3F, 900));
		send_item(mk(OP_START, MODE_LEFT, 0, 6'h00, 0));
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 4000, 6'h00, 0));    // left, nothing seen
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 4000, 6'h28, 1023));
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 2000, 6'h0C, 1023)); // window edges
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 3000, 6'h0C, 1023));
		send_item(mk(OP_START, MODE_UNKNOWN, 0, 6'h00, 0));         // restart, unknown mode
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 1234, 6'h3F, 800));  // at threshold: unseen
		send_item(mk(OP_SAMPLE, MODE_STRAIGHT, 1234, 6'h3F, 801));
		settle();

		// Random phases, one register setting each
		for (p = 0; p < NumPhases; p++) begin
			case (p)
				0:       begin thr = 0;    lim = 400; end
				1:       begin thr = 1023; lim = 1;   end
				2:       begin thr = 400;  lim = 0;   end
				3:       begin thr = 800;  lim = 200; end
				6:       begin thr = 1022; lim = 400; end
				default: begin
					thr = $urandom_range(1023, 0);
					lim = $urandom_range(400, 0);
				end
			endcase
			// one stretch without any idling on either side
			gaps_on   = (p != 3);
			stalls_on = (p != 3);
			apb_write({REG_THRESHOLD, 2'b00}, thr);
			apb_write({REG_LIMIT, 2'b00}, lim);
			cur_thr = thr;
			settings++;
			random_phase(PhaseItems);
			settle();
		end

		$display("covered %0d input transfers with %0d run starts and %0d intersections",
			items_sent, starts, intersections);
		$display("over %0d threshold and speed limit settings", settings);
		if (fail_count == 0 && outstanding == 0)
			$display("line_follow_motor_control_test: clean");
		else
			$display("line_follow_motor_control_test: errors");
		$finish;
	end

endmodule

### sim.f
hw/rtl/lfmc_pkg.sv
hw/rtl/line_follow_motor_control.sv
sim/line_follow_motor_control_checker.sv
sim/line_follow_motor_control_test.sv
